>>> hw/rtl/cwfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cwfc_pkg
// Shared types, constants and the CRC-8 byte update for the word frame checker.
// ----------------------------------------------------------------------------
package cwfc_pkg;

   localparam int MAX_WORDS    = 16;
   localparam int WORDS_W      = $clog2(MAX_WORDS + 1);
   localparam int WORD_COUNT_W = 5;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 8;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_WORD_COUNT     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC_POLYNOMIAL = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRC_INIT       = 2'd2;

   localparam logic [WORD_COUNT_W-1:0] WORD_COUNT_RESET = 5'd1;
   localparam logic [7:0]              CRC_POLY_RESET   = 8'h31;
   localparam logic [7:0]              CRC_INIT_RESET   = 8'hFF;
   localparam logic [7:0]              CRC_TOP_BIT      = 8'h80;

   typedef enum logic [1:0] {
      POS_HIGH,
      POS_LOW,
      POS_CHECK
   } pos_type;

   typedef struct packed {
      logic [WORD_COUNT_W-1:0] word_count;
      logic [7:0]              crc_polynomial;
      logic [7:0]              crc_init;
   } cfg_type;

   typedef struct packed {
      logic [15:0] data_word;
      logic        word_status;
      logic        last_word;
   } result_type;

   // MSB-first CRC-8 over one byte
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc,
                                            input logic [7:0] b,
                                            input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOP_BIT) != 8'd0) begin
            c = {c[6:0], 1'b0} ^ poly;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

>>> hw/rtl/crc8_word_frame_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc8_word_frame_checker
// Checks a byte stream of CRC-8 protected 16-bit words, one result per word up to a frame's first error.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one received byte per transfer; each word is data high, data low,
//   then the CRC-8 of those two. A byte is taken when req_valid is high and
//   req_stall is low. One byte is taken every cycle while the result queue
//   has room.
//   rsp_ channel returns one word per triple with its status (0 ok, 1 CRC
//   mismatch) and a last flag on the frame's final word or on the first
//   error. After an error the rest of the frame is dropped silently.
//   A result is registered into the queue when its checksum byte is taken and leaves
//   when rsp_valid is high and rsp_stall is low.
//   A two-entry queue sits between the intake and rsp_; req_stall rises only
//   while both entries are held, so a stalled receiver blocks input after
//   two pending words.
//   csr_ writes word_count, crc_polynomial and crc_init (always ready);
//   write only while idle.
//   Reset (synchronous) restores one word per frame, polynomial 0x31, init
//   0xFF, and empties the queue.
// ----------------------------------------------------------------------------
module crc8_word_frame_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [7:0]                         req_rx_byte,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [15:0]                             rsp_data_word,
   output logic                                    rsp_word_status,
   output logic                                    rsp_last_word,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [cwfc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [cwfc_pkg::CSR_DATA_W-1:0]    csr_data
);

   cwfc_pkg::cfg_type     cfg_ff, cfg_in;
   cwfc_pkg::result_type  push_entry;
   cwfc_pkg::result_type  head;
   logic                  push_valid;
   logic                  queue_full;
   logic                  queue_not_empty;
   logic                  in_accept;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            cwfc_pkg::CSR_WORD_COUNT: begin
               cfg_in.word_count = csr_data[cwfc_pkg::WORD_COUNT_W-1:0];
            end
            cwfc_pkg::CSR_CRC_POLYNOMIAL: begin
               cfg_in.crc_polynomial = csr_data;
            end
            cwfc_pkg::CSR_CRC_INIT: begin
               cfg_in.crc_init = csr_data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.word_count     <= cwfc_pkg::WORD_COUNT_RESET;
         cfg_ff.crc_polynomial <= cwfc_pkg::CRC_POLY_RESET;
         cfg_ff.crc_init       <= cwfc_pkg::CRC_INIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = queue_full;
   assign in_accept = req_valid & ~req_stall;

   cwfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_accept  (in_accept),
      .rx_byte    (req_rx_byte),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   cwfc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (~rsp_stall),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   assign rsp_valid       = queue_not_empty;
   assign rsp_data_word   = head.data_word;
   assign rsp_word_status = head.word_status;
   assign rsp_last_word   = head.last_word;

endmodule
`default_nettype wire

>>> hw/rtl/cwfc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cwfc_front
// Byte intake: runs the CRC, assembles each triple and classifies the word.
// ----------------------------------------------------------------------------
module cwfc_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cwfc_pkg::cfg_type    cfg,
   input  wire logic                 in_accept,
   input  wire logic [7:0]           rx_byte,
   output logic                      push_valid,
   output cwfc_pkg::result_type      push_entry
);

   cwfc_pkg::pos_type                 pos_ff, pos_in;
   logic [7:0]                        crc_ff, crc_in;
   logic [7:0]                        high_ff, high_in;
   logic [7:0]                        low_ff, low_in;
   logic [cwfc_pkg::WORDS_W-1:0]      seen_ff, seen_in;
   logic                              failed_ff, failed_in;

   logic [cwfc_pkg::WORDS_W-1:0]      eff_count;
   logic [cwfc_pkg::WORDS_W-1:0]      seen_inc;
   logic                              mismatch;
   logic                              frame_end;

   // zero acts as one word, oversize counts clamp
   always_comb begin
      if (cfg.word_count == '0) begin
         eff_count = cwfc_pkg::WORDS_W'(1);
      end else if (32'(cfg.word_count) > cwfc_pkg::MAX_WORDS) begin
         eff_count = cwfc_pkg::WORDS_W'(cwfc_pkg::MAX_WORDS);
      end else begin
         eff_count = cwfc_pkg::WORDS_W'(cfg.word_count);
      end
   end

   always_comb begin
      if (32'(seen_ff) < cwfc_pkg::MAX_WORDS) begin
         seen_inc = seen_ff + cwfc_pkg::WORDS_W'(1);
      end else begin
         seen_inc = seen_ff;
      end
      mismatch  = (crc_ff != rx_byte);
      frame_end = (seen_inc >= eff_count);
   end

   always_comb begin
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      high_in    = high_ff;
      low_in     = low_ff;
      seen_in    = seen_ff;
      failed_in  = failed_ff;
      push_valid = 1'b0;
      push_entry.data_word   = {high_ff, low_ff};
      push_entry.word_status = mismatch;
      push_entry.last_word   = mismatch | frame_end;
      if (in_accept) begin
         case (pos_ff)
            cwfc_pkg::POS_HIGH: begin
               high_in = rx_byte;
               crc_in  = cwfc_pkg::crc8_byte(cfg.crc_init, rx_byte, cfg.crc_polynomial);
               pos_in  = cwfc_pkg::POS_LOW;
            end
            cwfc_pkg::POS_LOW: begin
               low_in = rx_byte;
               crc_in = cwfc_pkg::crc8_byte(crc_ff, rx_byte, cfg.crc_polynomial);
               pos_in = cwfc_pkg::POS_CHECK;
            end
            cwfc_pkg::POS_CHECK: begin
               pos_in = cwfc_pkg::POS_HIGH;
               crc_in = cfg.crc_init;
               if (failed_ff) begin
                  // swallow the rest of the frame, rearm at its end
                  if (frame_end) begin
                     failed_in = 1'b0;
                     seen_in   = '0;
                  end else begin
                     seen_in = seen_inc;
                  end
               end else begin
                  push_valid = 1'b1;
                  if (frame_end) begin
                     seen_in = '0;
                  end else begin
                     seen_in = seen_inc;
                     if (mismatch) begin
                        failed_in = 1'b1;
                     end
                  end
               end
            end
            default: begin
               pos_in = cwfc_pkg::POS_HIGH;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= cwfc_pkg::POS_HIGH;
         crc_ff    <= cwfc_pkg::CRC_INIT_RESET;
         seen_ff   <= '0;
         failed_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         seen_ff   <= seen_in;
         failed_ff <= failed_in;
      end
      high_ff <= high_in;
      low_ff  <= low_in;
   end

endmodule
`default_nettype wire

>>> hw/rtl/cwfc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cwfc_queue
// Short result queue between the byte intake and the result channel.
// ----------------------------------------------------------------------------
module cwfc_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  wire cwfc_pkg::result_type push_entry,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      not_empty,
   output cwfc_pkg::result_type      head
);

   localparam int PTR_W = $clog2(cwfc_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(cwfc_pkg::QUEUE_DEPTH + 1);

   cwfc_pkg::result_type  entry_ff [cwfc_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  do_pop;

   assign full      = (32'(count_ff) == cwfc_pkg::QUEUE_DEPTH);
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];
   assign do_pop    = pop & not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (32'(wr_ptr_ff) == cwfc_pkg::QUEUE_DEPTH - 1) ? '0
                   : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == cwfc_pkg::QUEUE_DEPTH - 1) ? '0
                   : rd_ptr_ff + PTR_W'(1);
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !push_valid) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire
